// ===== src/ple_pkg.sv =====
package ple_pkg;

  localparam int SLOTS    = 64;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int MODE_W   = 3;
  localparam int POS_W    = 6;
  localparam int IN_VAL_W = 32;
  localparam int STAT_W   = 2;
  localparam int OUT_W    = 6;
  localparam int CMP_W    = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT       = 3'd0,
    MODE_DELETE       = 3'd1,
    MODE_LOCATE_FIRST = 3'd2,
    MODE_LOCATE_LAST  = 3'd3,
    MODE_REVERSE      = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOCATE,
    S_REVERSE
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_SEARCH,
    OP_LOAD_TAG,
    OP_SWAP
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [POS_W-1:0]  pos;
    logic [IDX_W-1:0]  count;
    logic              parity;
    logic [ELEM_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== src/positional_list_engine.sv =====
// Insert, delete, unused modes and any error load their result into the output register
//   at the accepting edge; locate first registers the cell matches, then loads the result;
//   reverse of a list does a tag load, one swap round per word, then the result load.
// Throughput: insert and delete take one word per cycle while the output register is free;
//   locate and reverse hold the input stalled until their result is loaded into the output register.
// Reset: list length zero, no result pending; the element cells are not cleared.
module positional_list_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ple_pkg::MODE_W-1:0]         mode_i,
  input  logic [ple_pkg::POS_W-1:0]          position_i,
  input  logic signed [ple_pkg::IN_VAL_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ple_pkg::STAT_W-1:0]         status_o,
  output logic [ple_pkg::OUT_W-1:0]          found_position_o,
  output logic [ple_pkg::OUT_W-1:0]          list_length_o
);

  ple_pkg::state_e            state_q, state_d;
  logic [ple_pkg::IDX_W-1:0]  count_q, count_d;
  logic [ple_pkg::IDX_W-1:0]  rnd_q, rnd_d;
  logic                       last_q, last_d;
  logic                       out_valid_q, out_valid_d;
  logic [ple_pkg::STAT_W-1:0] status_q, status_d;
  logic [ple_pkg::OUT_W-1:0]  found_q, found_d;
  logic [ple_pkg::OUT_W-1:0]  len_q, len_d;

  ple_pkg::mode_e             mode;
  ple_pkg::status_e           res_status;
  ple_pkg::cell_ctrl_t        ctrl;
  logic [ple_pkg::ELEM_W-1:0] elem_v;
  logic [ple_pkg::CMP_W-1:0]  pos_x, cnt_x;
  logic                       slot_free, accept, out_load, rev_done;
  logic                       ins_full, ins_range, del_empty, del_range;
  logic [ple_pkg::IDX_W-1:0]  found_idx, res_found;

  logic [ple_pkg::ELEM_W-1:0] cell_val [ple_pkg::SLOTS+1];
  logic [ple_pkg::IDX_W-1:0]  cell_tag [ple_pkg::SLOTS+1];
  logic [ple_pkg::SLOTS-1:0]  match_vec;

  assign mode      = ple_pkg::mode_e'(mode_i);
  assign elem_v    = ple_pkg::ELEM_W'(value_i);
  assign pos_x     = ple_pkg::CMP_W'(position_i);
  assign cnt_x     = ple_pkg::CMP_W'(count_q);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == ple_pkg::S_IDLE && slot_free);
  assign accept    = in_valid_i && !in_stall_o;
  assign rev_done  = (rnd_q == count_q);

  assign ins_full  = (count_q == ple_pkg::IDX_W'(ple_pkg::SLOTS - 1));
  assign ins_range = (pos_x == '0) || (pos_x > cnt_x + ple_pkg::CMP_W'(1));
  assign del_empty = (count_q == '0);
  assign del_range = (pos_x == '0) || (pos_x > cnt_x);

  // cell chain, positions 1 .. SLOTS-1; ends tied off
  assign cell_val[0]             = '0;
  assign cell_tag[0]             = '1;
  assign cell_val[ple_pkg::SLOTS] = '0;
  assign cell_tag[ple_pkg::SLOTS] = '0;
  assign match_vec[0]            = 1'b0;

  for (genvar g = 1; g < ple_pkg::SLOTS; g++) begin : g_cell
    ple_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (ple_pkg::IDX_W'(g)),
      .ctrl_i      (ctrl),
      .left_val_i  (cell_val[g-1]),
      .left_tag_i  (cell_tag[g-1]),
      .right_val_i (cell_val[g+1]),
      .right_tag_i (cell_tag[g+1]),
      .val_o       (cell_val[g]),
      .tag_o       (cell_tag[g]),
      .match_o     (match_vec[g])
    );
  end

  ple_locate u_locate (
    .match_i (match_vec),
    .last_i  (last_q),
    .pos_o   (found_idx)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ple_pkg::S_IDLE: begin
        if (accept) begin
          if (mode == ple_pkg::MODE_LOCATE_FIRST || mode == ple_pkg::MODE_LOCATE_LAST) begin
            state_d = ple_pkg::S_LOCATE;
          end else if (mode == ple_pkg::MODE_REVERSE) begin
            state_d = ple_pkg::S_REVERSE;
          end
        end
      end
      ple_pkg::S_LOCATE: begin
        if (slot_free) begin
          state_d = ple_pkg::S_IDLE;
        end
      end
      ple_pkg::S_REVERSE: begin
        if (rev_done && slot_free) begin
          state_d = ple_pkg::S_IDLE;
        end
      end
      default: state_d = ple_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op     = ple_pkg::OP_HOLD;
    ctrl.pos    = position_i;
    ctrl.count  = count_q;
    ctrl.parity = rnd_q[0];
    ctrl.value  = elem_v;
    out_load    = 1'b0;
    res_status  = ple_pkg::STAT_OK;
    res_found   = '0;
    count_d     = count_q;
    rnd_d       = rnd_q;
    last_d      = last_q;
    case (state_q)
      ple_pkg::S_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (mode)
            ple_pkg::MODE_INSERT: begin
              if (ins_full) begin
                res_status = ple_pkg::STAT_FULL;
              end else if (ins_range) begin
                res_status = ple_pkg::STAT_RANGE;
              end else begin
                ctrl.op = ple_pkg::OP_INSERT;
                count_d = count_q + ple_pkg::IDX_W'(1);
              end
            end
            ple_pkg::MODE_DELETE: begin
              if (del_empty) begin
                res_status = ple_pkg::STAT_EMPTY;
              end else if (del_range) begin
                res_status = ple_pkg::STAT_RANGE;
              end else begin
                ctrl.op = ple_pkg::OP_DELETE;
                count_d = count_q - ple_pkg::IDX_W'(1);
              end
            end
            ple_pkg::MODE_LOCATE_FIRST, ple_pkg::MODE_LOCATE_LAST: begin
              ctrl.op  = ple_pkg::OP_SEARCH;
              out_load = 1'b0;
              last_d   = (mode == ple_pkg::MODE_LOCATE_LAST);
            end
            ple_pkg::MODE_REVERSE: begin
              ctrl.op  = ple_pkg::OP_LOAD_TAG;
              out_load = 1'b0;
              rnd_d    = '0;
            end
            default: ;
          endcase
        end
      end
      ple_pkg::S_LOCATE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          res_found = found_idx;
        end
      end
      ple_pkg::S_REVERSE: begin
        if (rev_done) begin
          out_load = slot_free;
        end else begin
          ctrl.op = ple_pkg::OP_SWAP;
          rnd_d   = rnd_q + ple_pkg::IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    found_d     = found_q;
    len_d       = len_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      status_d    = res_status;
      found_d     = ple_pkg::OUT_W'(res_found);
      len_d       = ple_pkg::OUT_W'(count_d);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::S_IDLE;
      count_q     <= '0;
      rnd_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rnd_q       <= rnd_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
    len_q    <= len_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = found_q;
  assign list_length_o    = len_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ple_pkg::IDX_W'(ple_pkg::SLOTS - 1))
    else $error("list length beyond capacity");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ple_pkg::S_IDLE |-> in_stall_o)
    else $error("word taken while an operation is in progress");

  a_busy_len_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ple_pkg::S_IDLE |=> count_q == $past(count_q))
    else $error("list length changed during locate or reverse");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("result loaded over a pending word");
`endif

endmodule

// ===== src/ple_cell.sv =====
module ple_cell (
  input  logic                           clk_i,
  input  logic [ple_pkg::IDX_W-1:0]      idx_i,
  input  ple_pkg::cell_ctrl_t            ctrl_i,
  input  logic [ple_pkg::ELEM_W-1:0]     left_val_i,
  input  logic [ple_pkg::IDX_W-1:0]      left_tag_i,
  input  logic [ple_pkg::ELEM_W-1:0]     right_val_i,
  input  logic [ple_pkg::IDX_W-1:0]      right_tag_i,
  output logic [ple_pkg::ELEM_W-1:0]     val_o,
  output logic [ple_pkg::IDX_W-1:0]      tag_o,
  output logic                           match_o
);

  logic [ple_pkg::ELEM_W-1:0] val_q, val_d;
  logic [ple_pkg::IDX_W-1:0]  tag_q, tag_d;
  logic                       match_q, match_d;
  logic [ple_pkg::CMP_W-1:0]  idx_x, pos_x, cnt_x;
  logic                       pair_left;

  assign idx_x     = ple_pkg::CMP_W'(idx_i);
  assign pos_x     = ple_pkg::CMP_W'(ctrl_i.pos);
  assign cnt_x     = ple_pkg::CMP_W'(ctrl_i.count);
  // pairs (i, i+1) start on odd i in even rounds, on even i in odd rounds
  assign pair_left = (idx_i[0] != ctrl_i.parity);

  always_comb begin
    val_d   = val_q;
    tag_d   = tag_q;
    match_d = match_q;
    case (ctrl_i.op)
      ple_pkg::OP_INSERT: begin
        if (idx_x == pos_x) begin
          val_d = ctrl_i.value;
        end else if (idx_x > pos_x && idx_x <= cnt_x + ple_pkg::CMP_W'(1)) begin
          val_d = left_val_i;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (idx_x >= pos_x && idx_x < cnt_x) begin
          val_d = right_val_i;
        end
      end
      ple_pkg::OP_SEARCH: begin
        match_d = (val_q == ctrl_i.value) && (idx_x <= cnt_x);
      end
      ple_pkg::OP_LOAD_TAG: begin
        tag_d = idx_i;
      end
      ple_pkg::OP_SWAP: begin
        if (pair_left) begin
          if (idx_x + ple_pkg::CMP_W'(1) <= cnt_x && tag_q < right_tag_i) begin
            val_d = right_val_i;
            tag_d = right_tag_i;
          end
        end else begin
          if (idx_x <= cnt_x && left_tag_i < tag_q) begin
            val_d = left_val_i;
            tag_d = left_tag_i;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    tag_q   <= tag_d;
    match_q <= match_d;
  end

  assign val_o   = val_q;
  assign tag_o   = tag_q;
  assign match_o = match_q;

endmodule

// ===== src/ple_locate.sv =====
module ple_locate (
  input  logic [ple_pkg::SLOTS-1:0]  match_i,
  input  logic                       last_i,
  output logic [ple_pkg::IDX_W-1:0]  pos_o
);

  logic [ple_pkg::SLOTS-1:0] fwd, rev, oh_first, oh_last;
  logic [ple_pkg::IDX_W-1:0] first_idx, last_rev_idx;
  logic [ple_pkg::IDX_W-1:0] bitpos;

  always_comb begin
    for (int i = 0; i < ple_pkg::SLOTS; i++) begin
      rev[i] = match_i[ple_pkg::SLOTS-1-i];
    end
  end

  assign fwd      = match_i;
  assign oh_first = fwd & (~fwd + ple_pkg::SLOTS'(1));
  assign oh_last  = rev & (~rev + ple_pkg::SLOTS'(1));

  always_comb begin
    first_idx    = '0;
    last_rev_idx = '0;
    for (int i = 0; i < ple_pkg::SLOTS; i++) begin
      bitpos       = ple_pkg::IDX_W'(i);
      first_idx    = first_idx | ({ple_pkg::IDX_W{oh_first[i]}} & bitpos);
      last_rev_idx = last_rev_idx | ({ple_pkg::IDX_W{oh_last[i]}} & bitpos);
    end
  end

  always_comb begin
    if (!(|match_i)) begin
      pos_o = '0;
    end else if (last_i) begin
      pos_o = ple_pkg::IDX_W'(ple_pkg::SLOTS - 1) - last_rev_idx;
    end else begin
      pos_o = first_idx;
    end
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 120;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = ple_pkg::SLOTS + 16;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_SEGMENTS = 7;
  localparam int SEGMENT_WORDS = 200;

  localparam logic [ple_pkg::MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [ple_pkg::MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [ple_pkg::MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [ple_pkg::IN_VAL_W-1:0] VALUE_MIN = 32'h8000_0000;
  localparam logic [ple_pkg::IN_VAL_W-1:0] VALUE_MAX = 32'h7fff_ffff;

  typedef struct packed {
    ple_pkg::status_e          status;
    logic [ple_pkg::OUT_W-1:0] found;
    logic [ple_pkg::OUT_W-1:0] length;
  } outcome_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic [ple_pkg::MODE_W-1:0]          mode_i = '0;
  logic [ple_pkg::POS_W-1:0]           position_i = '0;
  logic signed [ple_pkg::IN_VAL_W-1:0] value_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [ple_pkg::STAT_W-1:0]          status_o;
  logic [ple_pkg::OUT_W-1:0]           found_position_o;
  logic [ple_pkg::OUT_W-1:0]           list_length_o;

  // shadow copy of the list, positions 1..list_len
  logic [ple_pkg::ELEM_W-1:0] list_mem [1:ple_pkg::SLOTS-1];
  int unsigned                list_len = 0;
  outcome_t                   expected_q [$];

  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned peak_length = 0;
  int unsigned full_rejects = 0;
  int unsigned reversals = 0;
  int unsigned hits = 0;

  positional_list_engine DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .list_length_o    (list_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic outcome_t apply_to_list(input logic [ple_pkg::MODE_W-1:0] m,
                                             input logic [ple_pkg::POS_W-1:0] p,
                                             input logic [ple_pkg::IN_VAL_W-1:0] v);
    outcome_t                   res;
    logic [ple_pkg::ELEM_W-1:0] word;
    logic [ple_pkg::ELEM_W-1:0] tmp;
    int                         j;
    int                         hit;
    word = ple_pkg::ELEM_W'($signed(v));
    hit = 0;
    res.status = ple_pkg::STAT_OK;
    case (m)
      ple_pkg::MODE_INSERT: begin
        if (list_len >= ple_pkg::SLOTS - 1) begin
          res.status = ple_pkg::STAT_FULL;
          full_rejects++;
        end else if (p < 1 || p > list_len + 1) begin
          res.status = ple_pkg::STAT_RANGE;
        end else begin
          for (j = int'(list_len); j >= int'(p); j--) list_mem[j+1] = list_mem[j];
          list_mem[p] = word;
          list_len++;
        end
      end
      ple_pkg::MODE_DELETE: begin
        if (list_len == 0) begin
          res.status = ple_pkg::STAT_EMPTY;
        end else if (p < 1 || p > list_len) begin
          res.status = ple_pkg::STAT_RANGE;
        end else begin
          for (j = int'(p) + 1; j <= int'(list_len); j++) list_mem[j-1] = list_mem[j];
          list_len--;
        end
      end
      ple_pkg::MODE_LOCATE_FIRST: begin
        for (j = 1; j <= int'(list_len) && hit == 0; j++)
          if (list_mem[j] == word) hit = j;
      end
      ple_pkg::MODE_LOCATE_LAST: begin
        for (j = int'(list_len); j >= 1 && hit == 0; j--)
          if (list_mem[j] == word) hit = j;
      end
      ple_pkg::MODE_REVERSE: begin
        reversals++;
        for (j = 1; j <= int'(list_len / 2); j++) begin
          tmp = list_mem[j];
          list_mem[j] = list_mem[list_len + 1 - j];
          list_mem[list_len + 1 - j] = tmp;
        end
      end
      default: ;
    endcase
    if (hit != 0) hits++;
    if (list_len > peak_length) peak_length = list_len;
    res.found = ple_pkg::OUT_W'(hit);
    res.length = ple_pkg::OUT_W'(list_len);
    return res;
  endfunction

  function automatic logic [ple_pkg::IN_VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) != 0) return $urandom;
    // small pool so that duplicates and hits are common
    return ($urandom_range(0, 1) != 0) ? ple_pkg::IN_VAL_W'($urandom_range(0, 3))
                                       : ~ple_pkg::IN_VAL_W'($urandom_range(0, 3));
  endfunction

  function automatic void flag(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on result %0d, %s: expected %0d, got %0d",
               results_checked, what, want, got);
  endfunction

  task automatic send_word(input logic [ple_pkg::MODE_W-1:0] m,
                           input logic [ple_pkg::POS_W-1:0] p,
                           input logic [ple_pkg::IN_VAL_W-1:0] v);
    in_valid_i <= 1'b1;
    mode_i <= m;
    position_i <= p;
    value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(apply_to_list(m, p, v));
    words_sent++;
    if (tx_idling && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_word(input int unsigned grow);
    int unsigned                  pick;
    int unsigned                  upper;
    logic [ple_pkg::MODE_W-1:0]   m;
    logic [ple_pkg::POS_W-1:0]    p;
    logic [ple_pkg::IN_VAL_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < grow) m = ple_pkg::MODE_INSERT;
    else if (pick < 65) m = ple_pkg::MODE_DELETE;
    else if (pick < 78) m = ple_pkg::MODE_LOCATE_FIRST;
    else if (pick < 91) m = ple_pkg::MODE_LOCATE_LAST;
    else if (pick < 96) m = ple_pkg::MODE_REVERSE;
    else m = ple_pkg::MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    upper = (m == ple_pkg::MODE_INSERT) ? list_len + 1 : list_len;
    if (upper > ple_pkg::SLOTS - 1) upper = ple_pkg::SLOTS - 1;
    if (upper == 0) upper = 1;
    p = ($urandom_range(0, 7) != 0) ? ple_pkg::POS_W'($urandom_range(1, upper))
                                    : ple_pkg::POS_W'($urandom);
    v = pick_value();
    if ((m == ple_pkg::MODE_LOCATE_FIRST || m == ple_pkg::MODE_LOCATE_LAST) &&
        list_len != 0 && $urandom_range(0, 4) < 3)
      v = list_mem[$urandom_range(1, list_len)];
    send_word(m, p, v);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    send_word(ple_pkg::MODE_DELETE, 6'd1, '0);
    send_word(ple_pkg::MODE_LOCATE_FIRST, 6'd0, '0);
    send_word(ple_pkg::MODE_LOCATE_LAST, 6'd0, '0);
    send_word(ple_pkg::MODE_REVERSE, 6'd0, '0);
    send_word(ple_pkg::MODE_INSERT, 6'd0, 32'd7);
    send_word(ple_pkg::MODE_INSERT, 6'd2, 32'd7);
    send_word(ple_pkg::MODE_INSERT, 6'd1, VALUE_MIN);
    send_word(ple_pkg::MODE_INSERT, 6'd2, VALUE_MAX);
    send_word(ple_pkg::MODE_INSERT, 6'd1, '0);
    send_word(ple_pkg::MODE_INSERT, 6'd2, '1);
    send_word(ple_pkg::MODE_INSERT, 6'd5, VALUE_MAX);
    send_word(ple_pkg::MODE_INSERT, 6'd63, 32'd9);
    send_word(ple_pkg::MODE_LOCATE_FIRST, 6'd0, VALUE_MAX);
    send_word(ple_pkg::MODE_LOCATE_LAST, 6'd63, VALUE_MAX);
    send_word(ple_pkg::MODE_LOCATE_FIRST, 6'd0, 32'd12345);
    send_word(ple_pkg::MODE_REVERSE, 6'd0, '0);
    send_word(ple_pkg::MODE_DELETE, 6'd0, '0);
    send_word(ple_pkg::MODE_DELETE, 6'd6, '0);
    send_word(ple_pkg::MODE_DELETE, 6'd5, '0);
    send_word(ple_pkg::MODE_REVERSE, 6'd63, '1);
    send_word(ple_pkg::MODE_DELETE, 6'd1, '0);
    send_word(MODE_SPARE_FIRST, 6'd63, '1);
    send_word(MODE_SPARE_MID, 6'd42, VALUE_MIN);
    send_word(MODE_SPARE_LAST, 6'd21, VALUE_MAX);
    send_word(ple_pkg::MODE_DELETE, 6'd63, '0);
    wait_drained();
  endtask

  task automatic test_fill_and_drain();
    while (list_len < ple_pkg::SLOTS - 1)
      send_word(ple_pkg::MODE_INSERT, ple_pkg::POS_W'($urandom_range(1, list_len + 1)),
                pick_value());
    send_word(ple_pkg::MODE_INSERT, 6'd1, pick_value());
    send_word(ple_pkg::MODE_INSERT, 6'd0, pick_value());
    send_word(ple_pkg::MODE_LOCATE_LAST, 6'd0, list_mem[1]);
    send_word(ple_pkg::MODE_REVERSE, 6'd0, '0);
    send_word(ple_pkg::MODE_LOCATE_FIRST, 6'd0, list_mem[ple_pkg::SLOTS-1]);
    send_word(ple_pkg::MODE_DELETE, ple_pkg::POS_W'(ple_pkg::SLOTS - 1), '0);
    send_word(ple_pkg::MODE_INSERT, ple_pkg::POS_W'(ple_pkg::SLOTS - 1), VALUE_MIN);
    while (list_len > 0)
      send_word(ple_pkg::MODE_DELETE, ple_pkg::POS_W'($urandom_range(1, list_len)), '0);
    send_word(ple_pkg::MODE_DELETE, ple_pkg::POS_W'($urandom), '0);
    wait_drained();
  endtask

  task automatic test_random_mix();
    for (int s = 0; s < RANDOM_SEGMENTS; s++) begin
      tx_idling = (s % 3 != 2);
      rx_idling <= (s % 3 != 1);
      repeat (SEGMENT_WORDS) send_random_word((s % 2 == 0) ? 50 : 22);
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_receiver_hold();
    tx_idling = 1'b0;
    rx_idling <= 1'b1;
    hold_token <= hold_token + 1;
    repeat (30) send_random_word(40);
    wait_drained();
  endtask

  task automatic test_quiet_tail();
    tx_idling = 1'b0;
    rx_idling <= 1'b0;
    repeat (150) send_random_word(35);
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_idling && $urandom_range(0, 9) == 0) begin
      burst_left <= $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (expected_q.size() == 0) begin
        flag("unexpected word, status", '0, 32'(status_o));
      end else begin
        want = expected_q.pop_front();
        if (status_o !== want.status)
          flag("status", 32'(want.status), 32'(status_o));
        if (found_position_o !== want.found)
          flag("found_position", 32'(want.found), 32'(found_position_o));
        if (list_length_o !== want.length)
          flag("list_length", 32'(want.length), 32'(list_length_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_fill_and_drain();
    test_random_mix();
    test_receiver_hold();
    test_quiet_tail();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d words sent, %0d results checked, %0d mismatches",
             words_sent, results_checked, mismatches);
    $display("list peaked at %0d entries; %0d full rejections, %0d reversals, %0d hits",
             peak_length, full_rejects, reversals, hits);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== positional_list_engine.f =====
src/ple_pkg.sv
src/ple_cell.sv
src/ple_locate.sv
src/positional_list_engine.sv
bench/tb.sv
